// ----- rtl/free_page_block_cache_defines.svh -----
// ----------------------------------------------------------------------------
// Free page block cache: assertion macros
// Shared property shorthands for the checker of the block.
// ----------------------------------------------------------------------------
`ifndef FREE_PAGE_BLOCK_CACHE_DEFINES_SVH
`define FREE_PAGE_BLOCK_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FPBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpbc: property failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FPBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpbc: property failed");

`endif

// ----- rtl/fpbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Free page block cache: package
// Sizes, codes and the table entry layout shared by the block's files.
// ----------------------------------------------------------------------------
package fpbc_pkg;

  localparam int N_ENT = 16;
  localparam int AW    = 48;
  localparam int LW    = 40;
  localparam int AGE_W = 3;
  localparam int PS_W  = 5;
  localparam int AL_W  = 6;
  localparam int IW    = $clog2(N_ENT);
  localparam int CW    = IW + 1;

  localparam logic [PS_W-1:0]  PAGE_SHIFT_RST  = PS_W'(12);
  localparam logic [LW-1:0]    MERGE_LIMIT_RST = LW'(1024 * 1024);
  localparam logic [AGE_W-1:0] UNMAP_AGE_RST   = AGE_W'(1);

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_FLUSH   = 2'd2;

  localparam logic [1:0] REG_PAGE_SHIFT  = 2'd0;
  localparam logic [1:0] REG_MERGE_LIMIT = 2'd1;
  localparam logic [1:0] REG_UNMAP_AGE   = 2'd2;

  typedef struct packed {
    logic [AW-1:0]    start;
    logic [LW-1:0]    len;
    logic [AGE_W-1:0] age;
    logic             zeroed;
  } entry_t;

  localparam int ENTRY_W = AW + LW + AGE_W + 1;

endpackage

// ----- rtl/fpbc_ram.sv -----
// ----------------------------------------------------------------------------
// Free page block cache: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fpbc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/free_page_block_cache.sv -----
// ----------------------------------------------------------------------------
// Free page block cache
// Table of free page blocks in two banked RAMs; exact-fit or first-fit allocate,
// release with merging, sort and coalesce, flush with aging.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         in_kind in_addr in_req_len in_align_log2
//                                 in_dirty_ok in_zeroed
//  result    out_valid (strobe)   out_addr out_len out_hit out_needs_clear
//                                 out_os_release out_last
//  config    cfg_we               cfg_idx cfg_wdata
//
// Allocate and plain release scan the table once through the RAM read port.
// Sort ranks each entry against all others, one scan per entry, then
// coalesce merges adjacent blocks in one more scan; a release into a full
// table runs sort and coalesce, and flush runs both and then a flush scan.
// The table is empty right out of reset: per-entry valid bits read unwritten
// entries as zero. Results come as one-cycle strobes; the receiver cannot stall.
module free_page_block_cache (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic [fpbc_pkg::AW-1:0]      in_addr,
  input  logic [fpbc_pkg::LW-1:0]      in_req_len,
  input  logic [fpbc_pkg::AL_W-1:0]    in_align_log2,
  input  logic                         in_dirty_ok,
  input  logic                         in_zeroed,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_idx,
  input  logic [fpbc_pkg::LW-1:0]      cfg_wdata,
  output logic                         out_valid,
  output logic [fpbc_pkg::AW-1:0]      out_addr,
  output logic [fpbc_pkg::LW-1:0]      out_len,
  output logic                         out_hit,
  output logic                         out_needs_clear,
  output logic                         out_os_release,
  output logic                         out_last
);

  localparam int AW = fpbc_pkg::AW;
  localparam int LW = fpbc_pkg::LW;
  localparam int IW = fpbc_pkg::IW;
  localparam int CW = fpbc_pkg::CW;
  localparam int NE = fpbc_pkg::N_ENT;
  localparam int EW = fpbc_pkg::ENTRY_W;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_A_SCAN = 15'h0002,
    ST_A_WR   = 15'h0004,
    ST_R_SCAN = 15'h0008,
    ST_R_WR   = 15'h0010,
    ST_S_ISS  = 15'h0020,
    ST_S_LAT  = 15'h0040,
    ST_S_SCAN = 15'h0080,
    ST_S_WR   = 15'h0100,
    ST_C_ISS  = 15'h0200,
    ST_C_LAT  = 15'h0400,
    ST_C_SCAN = 15'h0800,
    ST_C_END  = 15'h1000,
    ST_F_SCAN = 15'h2000,
    ST_F_END  = 15'h4000
  } state_t;

  // configuration
  logic [fpbc_pkg::PS_W-1:0]  page_shift_r;
  logic [LW-1:0]              merge_limit_r;
  logic [fpbc_pkg::AGE_W-1:0] unmap_age_r;

  // control
  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  logic [IW-1:0]  ridx_r, ridx_nxt;
  logic           rvld_r, rbank_r;
  logic           bank_r, bank_nxt;
  logic [NE-1:0]  valid_r, valid_nxt;
  logic           cand_found_r, cand_found_nxt;
  logic           ff_found_r, ff_found_nxt;
  logic           out_valid_r, out_valid_nxt;

  // request payload
  logic [1:0]     kind_r, kind_nxt;
  logic [AW-1:0]  p_r, p_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [AW-1:0]  amask_r, amask_nxt;
  logic           dirty_r, dirty_nxt;
  logic           z_r, z_nxt;

  // candidates found during a scan
  logic [IW-1:0]     cand_idx_r, cand_idx_nxt, ff_idx_r, ff_idx_nxt;
  fpbc_pkg::entry_t  cand_ent_r, cand_ent_nxt, ff_ent_r, ff_ent_nxt;
  logic [AW-1:0]     cand_addr_r, cand_addr_nxt, ff_addr_r, ff_addr_nxt;
  logic              cand_clr_r, cand_clr_nxt, ff_clr_r, ff_clr_nxt;

  // sort and coalesce
  logic [IW-1:0]     si_r, si_nxt, rank_r, rank_nxt, jidx_r, jidx_nxt;
  fpbc_pkg::entry_t  ent_i_r, ent_i_nxt, jent_r, jent_nxt;

  // result
  logic [AW-1:0]  out_addr_r, out_addr_nxt;
  logic [LW-1:0]  out_len_r, out_len_nxt;
  logic           out_hit_r, out_hit_nxt, out_clr_r, out_clr_nxt;
  logic           out_rel_r, out_rel_nxt, out_last_r, out_last_nxt;

  // RAM ports
  logic           wr_en, wr_bank;
  logic [IW-1:0]  waddr, raddr;
  logic [EW-1:0]  wdata, rd_a, rd_b;

  fpbc_ram #(.W(EW), .D(NE)) u_ram_a (
    .clk(clk), .we(wr_en && !wr_bank), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd_a)
  );

  fpbc_ram #(.W(EW), .D(NE)) u_ram_b (
    .clk(clk), .we(wr_en && wr_bank), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd_b)
  );

  // request rounding
  logic [LW:0]    pm, rsum, rnd;
  logic [LW-1:0]  len_rnd;
  always_comb begin
    pm      = (LW'(1) << page_shift_r) - (LW+1)'(1);
    rsum    = {1'b0, in_req_len} + pm;
    rnd     = rsum & ~pm;
    len_rnd = rnd[LW] ? ({LW{1'b1}} & ~pm[LW-1:0]) : rnd[LW-1:0];
  end

  // entry read this cycle, zero where never written
  fpbc_pkg::entry_t e;
  assign e = rvld_r ? fpbc_pkg::entry_t'(rbank_r ? rd_b : rd_a) : '0;

  logic           scan_st, issue, last_proc, e_nz;
  logic [LW-1:0]  a_rem;
  logic [AW-1:0]  a_send, a_cs;
  logic           a_exact, a_big, a_fs, a_fe;
  logic [LW:0]    r_sum, c_sum;
  logic           r_ok, r_after, r_before, bad_c;
  logic [AW:0]    p_end;
  logic           s_less;
  logic [AW-1:0]  c_end;
  logic           c_m;

  always_comb begin
    scan_st = (state_r == ST_A_SCAN) || (state_r == ST_R_SCAN) ||
              (state_r == ST_S_SCAN) || (state_r == ST_C_SCAN) ||
              (state_r == ST_F_SCAN);
    issue     = scan_st && (cnt_r < CW'(NE));
    last_proc = rd_pend_r && (ridx_r == IW'(NE - 1));
    e_nz      = (e.start != '0);

    a_rem   = e.len - len_r;
    a_send  = e.start + AW'(a_rem);
    a_cs    = e.start + AW'(len_r);
    a_exact = e_nz && (len_r != '0) && (e.len == len_r) && ((e.start & amask_r) == '0);
    a_big   = e_nz && (len_r != '0) && (e.len > len_r);
    a_fs    = a_big && ((e.start & amask_r) == '0);
    a_fe    = a_big && !a_fs && ((a_send & amask_r) == '0);

    r_sum    = {1'b0, e.len} + {1'b0, len_r};
    r_ok     = e_nz && (e.len < merge_limit_r) && !r_sum[LW];
    r_after  = r_ok && (p_r == (e.start + AW'(e.len)));
    r_before = r_ok && !r_after && ((p_r + AW'(len_r)) == e.start);
    p_end    = {1'b0, p_r} + (AW+1)'(len_r);
    bad_c    = (p_r == '0) || (len_r == '0) || (p_end > ((AW+1)'(1) << AW));

    s_less = (e.start < ent_i_r.start) || ((e.start == ent_i_r.start) && (ridx_r < si_r));

    c_end = jent_r.start + AW'(jent_r.len);
    c_sum = {1'b0, jent_r.len} + {1'b0, e.len};
    c_m   = (c_end == e.start) && !c_sum[LW];
  end

  assign raddr = (state_r == ST_S_ISS) ? si_r :
                 (state_r == ST_C_ISS) ? '0 : cnt_r[IW-1:0];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = issue ? cnt_r + CW'(1) : cnt_r;
    rd_pend_nxt    = issue;
    ridx_nxt       = cnt_r[IW-1:0];
    bank_nxt       = bank_r;
    valid_nxt      = valid_r;
    cand_found_nxt = cand_found_r;
    ff_found_nxt   = ff_found_r;
    kind_nxt       = kind_r;
    p_nxt          = p_r;
    len_nxt        = len_r;
    amask_nxt      = amask_r;
    dirty_nxt      = dirty_r;
    z_nxt          = z_r;
    cand_idx_nxt   = cand_idx_r;
    cand_ent_nxt   = cand_ent_r;
    cand_addr_nxt  = cand_addr_r;
    cand_clr_nxt   = cand_clr_r;
    ff_idx_nxt     = ff_idx_r;
    ff_ent_nxt     = ff_ent_r;
    ff_addr_nxt    = ff_addr_r;
    ff_clr_nxt     = ff_clr_r;
    si_nxt         = si_r;
    rank_nxt       = rank_r;
    ent_i_nxt      = ent_i_r;
    jidx_nxt       = jidx_r;
    jent_nxt       = jent_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_len_nxt    = out_len_r;
    out_hit_nxt    = out_hit_r;
    out_clr_nxt    = out_clr_r;
    out_rel_nxt    = out_rel_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_bank        = bank_r;
    waddr          = '0;
    wdata          = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt       = in_kind;
          p_nxt          = in_addr;
          len_nxt        = len_rnd;
          amask_nxt      = (AW'(1) << in_align_log2) - AW'(1);
          dirty_nxt      = in_dirty_ok;
          z_nxt          = in_zeroed;
          cand_found_nxt = 1'b0;
          ff_found_nxt   = 1'b0;
          cnt_nxt        = '0;
          si_nxt         = '0;
          case (in_kind)
            fpbc_pkg::KIND_ALLOC:   state_nxt = ST_A_SCAN;
            fpbc_pkg::KIND_RELEASE: state_nxt = ST_R_SCAN;
            fpbc_pkg::KIND_FLUSH:   state_nxt = ST_S_ISS;
            default: begin
              out_valid_nxt = 1'b1;
              out_addr_nxt  = '0;
              out_len_nxt   = '0;
              out_hit_nxt   = 1'b0;
              out_clr_nxt   = 1'b0;
              out_rel_nxt   = 1'b0;
              out_last_nxt  = 1'b1;
            end
          endcase
        end
      end

      ST_A_SCAN: begin
        if (rd_pend_r) begin
          if (a_exact && !cand_found_r) begin
            cand_found_nxt = 1'b1;
            cand_idx_nxt   = ridx_r;
            cand_ent_nxt   = '{start: '0, len: '0, age: e.age, zeroed: e.zeroed};
            cand_addr_nxt  = e.start;
            cand_clr_nxt   = !e.zeroed && !dirty_r;
          end
          if ((a_fs || a_fe) && !ff_found_r) begin
            ff_found_nxt = 1'b1;
            ff_idx_nxt   = ridx_r;
            ff_ent_nxt   = '{start: (a_fs ? a_cs : e.start), len: a_rem,
                             age: e.age, zeroed: e.zeroed};
            ff_addr_nxt  = a_fs ? e.start : a_send;
            ff_clr_nxt   = !e.zeroed && !dirty_r;
          end
          if (last_proc) begin
            state_nxt = ST_A_WR;
          end
        end
      end

      ST_A_WR: begin
        out_valid_nxt = 1'b1;
        out_len_nxt   = len_r;
        out_rel_nxt   = 1'b0;
        out_last_nxt  = 1'b1;
        out_hit_nxt   = cand_found_r || ff_found_r;
        if (cand_found_r) begin
          wr_en        = 1'b1;
          waddr        = cand_idx_r;
          wdata        = cand_ent_r;
          out_addr_nxt = cand_addr_r;
          out_clr_nxt  = cand_clr_r;
        end else if (ff_found_r) begin
          wr_en        = 1'b1;
          waddr        = ff_idx_r;
          wdata        = ff_ent_r;
          out_addr_nxt = ff_addr_r;
          out_clr_nxt  = ff_clr_r;
        end else begin
          out_addr_nxt = '0;
          out_clr_nxt  = 1'b0;
        end
        state_nxt = ST_IDLE;
      end

      ST_R_SCAN: begin
        if (bad_c) begin
          // drop a release that is empty, starts at address zero or runs off the address space
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_len_nxt   = '0;
          out_hit_nxt   = 1'b0;
          out_clr_nxt   = 1'b0;
          out_rel_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (rd_pend_r) begin
          if ((r_after || r_before) && !cand_found_r) begin
            cand_found_nxt = 1'b1;
            cand_idx_nxt   = ridx_r;
            cand_ent_nxt   = '{start: (r_after ? e.start : p_r), len: r_sum[LW-1:0],
                               age: e.age, zeroed: e.zeroed && z_r};
          end
          if (!e_nz && !ff_found_r) begin
            ff_found_nxt = 1'b1;
            ff_idx_nxt   = ridx_r;
            ff_ent_nxt   = '{start: p_r, len: len_r, age: '0, zeroed: z_r};
          end
          if (last_proc) begin
            state_nxt = ST_R_WR;
          end
        end
      end

      ST_R_WR: begin
        if (cand_found_r || ff_found_r) begin
          wr_en         = 1'b1;
          waddr         = cand_found_r ? cand_idx_r : ff_idx_r;
          wdata         = cand_found_r ? cand_ent_r : ff_ent_r;
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_len_nxt   = '0;
          out_hit_nxt   = 1'b0;
          out_clr_nxt   = 1'b0;
          out_rel_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          si_nxt    = '0;
          state_nxt = ST_S_ISS;
        end
      end

      ST_S_ISS: state_nxt = ST_S_LAT;

      ST_S_LAT: begin
        ent_i_nxt = e;
        rank_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = ST_S_SCAN;
      end

      ST_S_SCAN: begin
        if (rd_pend_r) begin
          rank_nxt = rank_r + IW'(s_less);
          if (last_proc) begin
            state_nxt = ST_S_WR;
          end
        end
      end

      ST_S_WR: begin
        // place the entry at its rank in the other bank
        wr_en   = 1'b1;
        wr_bank = !bank_r;
        waddr   = rank_r;
        wdata   = ent_i_r;
        if (si_r == IW'(NE - 1)) begin
          bank_nxt  = !bank_r;
          valid_nxt = '1;
          state_nxt = ST_C_ISS;
        end else begin
          si_nxt    = si_r + IW'(1);
          state_nxt = ST_S_ISS;
        end
      end

      ST_C_ISS: state_nxt = ST_C_LAT;

      ST_C_LAT: begin
        jent_nxt  = e;
        jidx_nxt  = '0;
        cnt_nxt   = CW'(1);
        state_nxt = ST_C_SCAN;
      end

      ST_C_SCAN: begin
        if (rd_pend_r) begin
          wr_en = 1'b1;
          if (c_m) begin
            jent_nxt.len = c_sum[LW-1:0];
            if (!e.zeroed) begin
              jent_nxt.zeroed = 1'b0;
            end
            waddr = ridx_r;
            wdata = fpbc_pkg::entry_t'{start: '0, len: '0, age: e.age, zeroed: e.zeroed};
          end else begin
            waddr    = jidx_r;
            wdata    = jent_r;
            jent_nxt = e;
            jidx_nxt = ridx_r;
          end
          if (last_proc) begin
            state_nxt = ST_C_END;
          end
        end
      end

      ST_C_END: begin
        wr_en = 1'b1;
        waddr = jidx_r;
        wdata = jent_r;
        if (kind_r == fpbc_pkg::KIND_FLUSH) begin
          cnt_nxt   = '0;
          state_nxt = ST_F_SCAN;
        end else begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = p_r;
          out_len_nxt   = len_r;
          out_hit_nxt   = 1'b0;
          out_clr_nxt   = 1'b0;
          out_rel_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_F_SCAN: begin
        if (rd_pend_r) begin
          if (e_nz) begin
            wr_en = 1'b1;
            waddr = ridx_r;
            if (e.age == unmap_age_r) begin
              wdata         = '0;
              out_valid_nxt = 1'b1;
              out_addr_nxt  = e.start;
              out_len_nxt   = e.len;
              out_hit_nxt   = 1'b0;
              out_clr_nxt   = 1'b0;
              out_rel_nxt   = 1'b1;
              out_last_nxt  = 1'b0;
            end else begin
              wdata = fpbc_pkg::entry_t'{start: e.start, len: e.len, age: e.age + 3'd1,
                                         zeroed: e.zeroed};
            end
          end
          if (last_proc) begin
            state_nxt = ST_F_END;
          end
        end
      end

      ST_F_END: begin
        out_valid_nxt = 1'b1;
        out_addr_nxt  = '0;
        out_len_nxt   = '0;
        out_hit_nxt   = 1'b0;
        out_clr_nxt   = 1'b0;
        out_rel_nxt   = 1'b0;
        out_last_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase

    // mark entries of the live bank as written
    if (wr_en && (wr_bank == bank_r)) begin
      valid_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      rd_pend_r     <= 1'b0;
      bank_r        <= 1'b0;
      valid_r       <= '0;
      cand_found_r  <= 1'b0;
      ff_found_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      page_shift_r  <= fpbc_pkg::PAGE_SHIFT_RST;
      merge_limit_r <= fpbc_pkg::MERGE_LIMIT_RST;
      unmap_age_r   <= fpbc_pkg::UNMAP_AGE_RST;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rd_pend_r    <= rd_pend_nxt;
      bank_r       <= bank_nxt;
      valid_r      <= valid_nxt;
      cand_found_r <= cand_found_nxt;
      ff_found_r   <= ff_found_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          fpbc_pkg::REG_PAGE_SHIFT:  page_shift_r  <= cfg_wdata[fpbc_pkg::PS_W-1:0];
          fpbc_pkg::REG_MERGE_LIMIT: merge_limit_r <= cfg_wdata;
          fpbc_pkg::REG_UNMAP_AGE:   unmap_age_r   <= cfg_wdata[fpbc_pkg::AGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx_r      <= ridx_nxt;
    rvld_r      <= valid_r[raddr];
    rbank_r     <= bank_r;
    kind_r      <= kind_nxt;
    p_r         <= p_nxt;
    len_r       <= len_nxt;
    amask_r     <= amask_nxt;
    dirty_r     <= dirty_nxt;
    z_r         <= z_nxt;
    cand_idx_r  <= cand_idx_nxt;
    cand_ent_r  <= cand_ent_nxt;
    cand_addr_r <= cand_addr_nxt;
    cand_clr_r  <= cand_clr_nxt;
    ff_idx_r    <= ff_idx_nxt;
    ff_ent_r    <= ff_ent_nxt;
    ff_addr_r   <= ff_addr_nxt;
    ff_clr_r    <= ff_clr_nxt;
    si_r        <= si_nxt;
    rank_r      <= rank_nxt;
    ent_i_r     <= ent_i_nxt;
    jidx_r      <= jidx_nxt;
    jent_r      <= jent_nxt;
    out_addr_r  <= out_addr_nxt;
    out_len_r   <= out_len_nxt;
    out_hit_r   <= out_hit_nxt;
    out_clr_r   <= out_clr_nxt;
    out_rel_r   <= out_rel_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_addr        = out_addr_r;
  assign out_len         = out_len_r;
  assign out_hit         = out_hit_r;
  assign out_needs_clear = out_clr_r;
  assign out_os_release  = out_rel_r;
  assign out_last        = out_last_r;

endmodule

// ----- rtl/fpbc_checker.sv -----
// ----------------------------------------------------------------------------
// Free page block cache: port checker
// Watches result flags and busy against requests at the top-level ports.
// ----------------------------------------------------------------------------
`include "free_page_block_cache_defines.svh"

module fpbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_kind,
  input logic       out_valid,
  input logic       out_hit,
  input logic       out_needs_clear,
  input logic       out_os_release,
  input logic       out_last
);

  `FPBC_ASSERT_IMP(a_clear_needs_hit, out_valid && out_needs_clear, out_hit)
  `FPBC_ASSERT_IMP(a_hit_is_single, out_valid && out_hit, !out_os_release && out_last)
  `FPBC_ASSERT_IMP(a_more_only_unmap, out_valid && !out_last, busy && out_os_release)
  `FPBC_ASSERT_NXT(a_flush_busy, start && !busy && (in_kind == fpbc_pkg::KIND_FLUSH), busy)

endmodule

bind free_page_block_cache fpbc_checker u_fpbc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_kind(in_kind),
  .out_valid(out_valid), .out_hit(out_hit), .out_needs_clear(out_needs_clear),
  .out_os_release(out_os_release), .out_last(out_last)
);

// ----- tb/free_page_block_cache_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free page block cache: result checker
// Watches the request, result and register ports of the block, keeps its own
// copy of the free block table, predicts every result and compares each one
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module free_page_block_cache_checker
  import fpbc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  logic [1:0]    in_kind,
  input  logic [AW-1:0] in_addr,
  input  logic [LW-1:0] in_req_len,
  input  logic [AL_W-1:0] in_align_log2,
  input  logic          in_dirty_ok,
  input  logic          in_zeroed,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [LW-1:0] cfg_wdata,
  input  logic          out_valid,
  input  logic [AW-1:0] out_addr,
  input  logic [LW-1:0] out_len,
  input  logic          out_hit,
  input  logic          out_needs_clear,
  input  logic          out_os_release,
  input  logic          out_last,
  output int            fail_cnt,
  output int            pending
);

  localparam logic [63:0] AMASK = (64'd1 << AW) - 1;
  localparam logic [63:0] LMAX  = (64'd1 << LW) - 1;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic [LW-1:0] len;
    logic          hit;
    logic          clr;
    logic          rel;
    logic          last;
  } block_result_t;

  block_result_t result_q[$];

  logic [63:0]      blk_start [N_ENT];
  logic [63:0]      blk_len   [N_ENT];
  logic [AGE_W-1:0] blk_age   [N_ENT];
  logic             blk_zero  [N_ENT];

  logic [PS_W-1:0]  page_shift;
  logic [63:0]      merge_limit;
  logic [AGE_W-1:0] unmap_age;

  assign pending = result_q.size();

  function automatic logic [63:0] page_round(logic [63:0] len);
    logic [63:0] pm;
    logic [63:0] r;
    pm = (64'd1 << page_shift) - 1;
    r = (len + pm) & ~pm;
    if (r > LMAX) r = LMAX & ~pm;
    return r;
  endfunction

  task automatic post(logic [63:0] a, logic [63:0] l, logic h, logic c, logic rl,
                      logic lst);
    block_result_t r;
    r.addr = a[AW-1:0];
    r.len  = l[LW-1:0];
    r.hit  = h;
    r.clr  = c;
    r.rel  = rl;
    r.last = lst;
    result_q.push_back(r);
  endtask

  task automatic sort_and_merge();
    logic [63:0] s, l, e;
    logic [AGE_W-1:0] a;
    logic z;
    int j;
    for (int i = 1; i < N_ENT; i++) begin
      s = blk_start[i]; l = blk_len[i]; a = blk_age[i]; z = blk_zero[i];
      j = i - 1;
      while (j >= 0 && blk_start[j] > s) begin
        blk_start[j+1] = blk_start[j];
        blk_len[j+1]   = blk_len[j];
        blk_age[j+1]   = blk_age[j];
        blk_zero[j+1]  = blk_zero[j];
        j--;
      end
      blk_start[j+1] = s; blk_len[j+1] = l; blk_age[j+1] = a; blk_zero[j+1] = z;
    end
    j = 0;
    for (int i = 1; i < N_ENT; i++) begin
      e = (blk_start[j] + blk_len[j]) & AMASK;
      if (e == blk_start[i] && blk_len[i] <= LMAX - blk_len[j]) begin
        blk_len[j] = blk_len[j] + blk_len[i];
        blk_start[i] = 0;
        blk_len[i] = 0;
        if (!blk_zero[i]) blk_zero[j] = 1'b0;
      end else begin
        j = i;
      end
    end
  endtask

  task automatic predict_alloc(logic [63:0] req, logic [5:0] al, logic dirty);
    logic [63:0] len, amask, r;
    len = page_round(req);
    amask = (al != 0) ? ((64'd1 << al) - 1) : 64'd0;
    if (len != 0) begin
      for (int i = 0; i < N_ENT; i++) begin
        r = blk_start[i];
        if (r != 0 && blk_len[i] == len && (r & amask) == 0) begin
          blk_start[i] = 0;
          blk_len[i] = 0;
          post(r, len, 1'b1, !blk_zero[i] && !dirty, 1'b0, 1'b1);
          return;
        end
      end
      for (int i = 0; i < N_ENT; i++) begin
        r = blk_start[i];
        if (r != 0 && blk_len[i] > len) begin
          // carve from the front if aligned, else try the tail
          if ((r & amask) == 0) begin
            blk_start[i] = (r + len) & AMASK;
            blk_len[i] = blk_len[i] - len;
            post(r, len, 1'b1, !blk_zero[i] && !dirty, 1'b0, 1'b1);
            return;
          end
          r = (r + (blk_len[i] - len)) & AMASK;
          if ((r & amask) == 0) begin
            blk_len[i] = blk_len[i] - len;
            post(r, len, 1'b1, !blk_zero[i] && !dirty, 1'b0, 1'b1);
            return;
          end
        end
      end
    end
    post(0, len, 1'b0, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic predict_release(logic [63:0] p, logic [63:0] req, logic z);
    logic [63:0] len;
    len = page_round(req);
    if (p == 0 || len == 0 || len - 1 > AMASK - p) begin
      post(0, 0, 0, 0, 0, 1);
      return;
    end
    for (int i = 0; i < N_ENT; i++) begin
      if (blk_start[i] != 0 && blk_len[i] < merge_limit && len <= LMAX - blk_len[i])
      begin
        if (p == ((blk_start[i] + blk_len[i]) & AMASK)) begin
          blk_len[i] = blk_len[i] + len;
          if (!z) blk_zero[i] = 1'b0;
          post(0, 0, 0, 0, 0, 1);
          return;
        end
        if (((p + len) & AMASK) == blk_start[i]) begin
          blk_start[i] = p;
          blk_len[i] = blk_len[i] + len;
          if (!z) blk_zero[i] = 1'b0;
          post(0, 0, 0, 0, 0, 1);
          return;
        end
      end
    end
    for (int i = 0; i < N_ENT; i++) begin
      if (blk_start[i] == 0) begin
        blk_start[i] = p;
        blk_len[i] = len;
        blk_age[i] = 0;
        blk_zero[i] = z;
        post(0, 0, 0, 0, 0, 1);
        return;
      end
    end
    sort_and_merge();
    post(p, len, 0, 0, 1, 1);
  endtask

  task automatic predict_flush();
    sort_and_merge();
    for (int i = 0; i < N_ENT; i++) begin
      if (blk_start[i] != 0) begin
        if (blk_age[i] == unmap_age) begin
          post(blk_start[i], blk_len[i], 0, 0, 1, 0);
          blk_start[i] = 0;
          blk_len[i] = 0;
          blk_age[i] = 0;
          blk_zero[i] = 0;
        end else begin
          blk_age[i] = blk_age[i] + 1'b1;
        end
      end
    end
    post(0, 0, 0, 0, 0, 1);
  endtask

  always @(posedge clk) begin
    block_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < N_ENT; i++) begin
        blk_start[i] = 0; blk_len[i] = 0; blk_age[i] = 0; blk_zero[i] = 0;
      end
      page_shift  = PAGE_SHIFT_RST;
      merge_limit = 64'(MERGE_LIMIT_RST);
      unmap_age   = UNMAP_AGE_RST;
      result_q.delete();
      fail_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_PAGE_SHIFT:  page_shift  = cfg_wdata[PS_W-1:0];
          REG_MERGE_LIMIT: merge_limit = 64'(cfg_wdata);
          REG_UNMAP_AGE:   unmap_age   = cfg_wdata[AGE_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_kind)
          KIND_ALLOC:   predict_alloc(64'(in_req_len), in_align_log2, in_dirty_ok);
          KIND_RELEASE: predict_release(64'(in_addr), 64'(in_req_len), in_zeroed);
          KIND_FLUSH:   predict_flush();
          default:      post(0, 0, 0, 0, 0, 1);
        endcase
      end
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result addr=%h len=%h", $time, out_addr, out_len);
          fail_cnt++;
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r.addr !== out_addr) begin
            $display("%0t: addr exp=%h got=%h", $time, exp_r.addr, out_addr);
            fail_cnt++;
          end
          if (exp_r.len !== out_len) begin
            $display("%0t: len exp=%h got=%h", $time, exp_r.len, out_len);
            fail_cnt++;
          end
          if (exp_r.hit !== out_hit) begin
            $display("%0t: hit exp=%b got=%b", $time, exp_r.hit, out_hit);
            fail_cnt++;
          end
          if (exp_r.clr !== out_needs_clear) begin
            $display("%0t: needs_clear exp=%b got=%b", $time, exp_r.clr, out_needs_clear);
            fail_cnt++;
          end
          if (exp_r.rel !== out_os_release) begin
            $display("%0t: os_release exp=%b got=%b", $time, exp_r.rel, out_os_release);
            fail_cnt++;
          end
          if (exp_r.last !== out_last) begin
            $display("%0t: last exp=%b got=%b", $time, exp_r.last, out_last);
            fail_cnt++;
          end
        end
      end
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free page block cache: testbench top
// Drives directed and random allocate, release and flush requests through
// four register settings and three idle patterns; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import fpbc_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_kind;
  logic [AW-1:0] in_addr;
  logic [LW-1:0] in_req_len;
  logic [AL_W-1:0] in_align_log2;
  logic in_dirty_ok;
  logic in_zeroed;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [LW-1:0] cfg_wdata;
  logic out_valid;
  logic [AW-1:0] out_addr;
  logic [LW-1:0] out_len;
  logic out_hit;
  logic out_needs_clear;
  logic out_os_release;
  logic out_last;
  int fail_cnt;
  int pending;
  int idle_pct;
  int stall_cnt;
  logic [PS_W-1:0] cur_shift;

  free_page_block_cache dut (.*);
  free_page_block_cache_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send(logic [1:0] k, logic [AW-1:0] a, logic [LW-1:0] l,
                      logic [AL_W-1:0] al, logic d, logic z);
    in_kind <= k;
    in_addr <= a;
    in_req_len <= l;
    in_align_log2 <= al;
    in_dirty_ok <= d;
    in_zeroed <= z;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    // hold off the next request now and then
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [LW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(logic [PS_W-1:0] ps, logic [LW-1:0] ml, logic [AGE_W-1:0] ua);
    write_reg(REG_PAGE_SHIFT, LW'(ps));
    write_reg(REG_MERGE_LIMIT, ml);
    write_reg(REG_UNMAP_AGE, LW'(ua));
    cur_shift = ps;
  endtask

  task automatic random_phase(int n);
    int sel;
    logic [1:0] k;
    logic [AW-1:0] a;
    logic [LW-1:0] l;
    logic [AL_W-1:0] al;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      k = (sel < 45) ? KIND_RELEASE : (sel < 85) ? KIND_ALLOC :
          (sel < 95) ? KIND_FLUSH : KIND_UNUSED;
      // clustered, page-granular blocks so merges and fits happen often
      a = AW'(64'h1000_0000 + (64'($urandom_range(0, 63)) << cur_shift));
      l = LW'(64'($urandom_range(1, 6)) << cur_shift);
      if ($urandom_range(0, 3) == 0) l = l - LW'($urandom_range(0, 4095));
      al = AL_W'($urandom_range(0, cur_shift + 3));
      if ($urandom_range(0, 9) == 0) begin
        a = AW'({$urandom, $urandom});
        l = LW'({$urandom, $urandom});
        al = AL_W'($urandom);
      end
      send(k, a, l, al, 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_ALLOC;
    in_addr = '0;
    in_req_len = '0;
    in_align_log2 = '0;
    in_dirty_ok = 1'b0;
    in_zeroed = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_PAGE_SHIFT;
    cfg_wdata = '0;
    stall_cnt = 0;
    idle_pct = 33;
    cur_shift = PAGE_SHIFT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(5'd12, LW'(64'h10_0000), 3'd1);
    // directed: empty table, ignored releases, merges, fits and carving
    send(KIND_ALLOC, '0, 40'h1000, 0, 0, 0);
    send(KIND_ALLOC, '0, 40'h0, 0, 0, 0);
    send(KIND_RELEASE, '0, 40'h1000, 0, 0, 1);
    send(KIND_RELEASE, 48'h10_0000, 40'h0, 0, 0, 1);
    send(KIND_RELEASE, 48'hFFFF_FFFF_F000, 40'h2000, 0, 0, 0);
    send(KIND_RELEASE, 48'hFFFF_FFFF_F000, 40'h1000, 0, 0, 0);
    send(KIND_RELEASE, 48'h10_0000, 40'h3000, 0, 0, 1);
    send(KIND_RELEASE, 48'h10_3000, 40'h0FFF, 0, 0, 0);
    send(KIND_RELEASE, 48'h0F_F000, 40'h1000, 0, 0, 1);
    send(KIND_ALLOC, '0, 40'h5000, 0, 0, 0);
    send(KIND_RELEASE, 48'h20_0000, 40'h1_0000, 0, 0, 1);
    send(KIND_ALLOC, '0, 40'h1000, 6'd16, 0, 0);
    send(KIND_ALLOC, '0, 40'h1000, 6'd16, 1, 0);
    send(KIND_ALLOC, '0, 40'h800, 6'd12, 1, 0);
    send(KIND_ALLOC, '0, 40'hFF_FFFF_FFFF, 6'd63, 0, 0);
    send(KIND_UNUSED, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 6'd63, 1, 1);
    send(KIND_FLUSH, '0, '0, 0, 0, 0);
    send(KIND_FLUSH, '0, '0, 0, 0, 0);
    // fill the table past capacity to force sort, coalesce and unmap
    for (int i = 0; i < 18; i++)
      send(KIND_RELEASE, AW'(48'h100_0000 + i * 48'h2_0000), 40'h1000, 0, 0, i[0]);
    send(KIND_FLUSH, '0, '0, 0, 0, 0);
    send(KIND_FLUSH, '0, '0, 0, 0, 0);
    random_phase(60);
    drain();

    idle_pct = 86;
    set_regs(5'd24, LW'(64'hFF_FFFF_FFFF), 3'd7);
    random_phase(60);
    drain();

    idle_pct = 0;
    set_regs(5'd16, '0, 3'd0);
    random_phase(60);
    drain();

    set_regs(5'd12, LW'(64'h4000), 3'd2);
    random_phase(20);
    drain();
    repeat (400) @(posedge clk);

    if (fail_cnt == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fpbc_pkg.sv
rtl/fpbc_ram.sv
rtl/free_page_block_cache.sv
rtl/fpbc_checker.sv
tb/free_page_block_cache_checker.sv
tb/testbench.sv
